@@ hw/rtl/command_access_gate_assert.svh @@
// Assertion macros used by the command access gate core (cag_core).
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef COMMAND_ACCESS_GATE_ASSERT_SVH
`define COMMAND_ACCESS_GATE_ASSERT_SVH

// Check that holds at every clock edge outside reset
`define CAG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define CAG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cag_pkg.sv @@
// Shared types, codes and constants for the command access gate.
// No dependencies; used by the channel interfaces and all RTL modules.
`default_nettype none

package cag_pkg;

	// Command codes of an incoming request
	typedef enum logic [1:0] {
		CMD_CHECK  = 2'd0,
		CMD_STATUS = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BLOCK_TICKS    = 3'd0,
		REG_END_BOOT       = 3'd1,
		REG_REGULAR_TMO    = 3'd2,
		REG_UPGRADE_TMO    = 3'd3,
		REG_SMALLEST_TMO   = 3'd4
	} reg_idx_t;

	localparam int unsigned TICKS_W = 24;
	localparam int unsigned TMO_W   = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned SEEN_W  = 4;

	// Status byte bit that flags an update in progress
	localparam logic [BYTE_W-1:0] UPDATE_MASK = 8'h02;

	// Early-boot whitelist
	localparam logic [BYTE_W-1:0] WL_INS0 = 8'h09;
	localparam logic [BYTE_W-1:0] WL_INS1 = 8'h2A;
	localparam logic [BYTE_W-1:0] WL_INS2 = 8'h2D;
	localparam logic [BYTE_W-1:0] WL_INS3 = 8'h2F;

	typedef logic [TICKS_W-1:0] ticks_t;
	typedef logic [TMO_W-1:0]   tmo_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [SEEN_W-1:0]  seen_t;

	typedef struct packed {
		cmd_t  command;
		byte_t instr_byte;
		byte_t status_byte;
	} item_t;

	typedef struct packed {
		logic instr_pass;
		logic select_pass;
		tmo_t session_timeout;
		logic update_active;
		logic boot_done;
		logic access_open;
	} result_t;

	typedef struct packed {
		ticks_t block_ticks;
		byte_t  end_boot_opcode;
		tmo_t   regular_timeout;
		tmo_t   upgrade_timeout;
		tmo_t   smallest_timeout;
	} cfg_t;

	// One-hot seen bit for a whitelisted instruction, zero otherwise
	function automatic seen_t whitelist_hit(input byte_t ins);
		seen_t hit;
		hit = '0;
		case (ins)
			WL_INS0: hit = 4'b0001;
			WL_INS1: hit = 4'b0010;
			WL_INS2: hit = 4'b0100;
			WL_INS3: hit = 4'b1000;
			default: hit = '0;
		endcase
		return hit;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cag_channels.sv @@
// Valid/ready channel interfaces for requests and results of the gate.
// Depends on cag_pkg for field types.
`default_nettype none

interface cag_req_if;
	logic               valid;
	logic               ready;
	cag_pkg::cmd_t      command;
	cag_pkg::byte_t     instr_byte;
	cag_pkg::byte_t     status_byte;

	modport source (output valid, command, instr_byte, status_byte, input ready);
	modport sink   (input valid, command, instr_byte, status_byte, output ready);
endinterface

interface cag_rsp_if;
	logic               valid;
	logic               ready;
	logic               instr_pass;
	logic               select_pass;
	cag_pkg::tmo_t      session_timeout;
	logic               update_active;
	logic               boot_done;
	logic               access_open;

	modport source (output valid, instr_pass, select_pass, session_timeout,
		update_active, boot_done, access_open, input ready);
	modport sink   (input valid, instr_pass, select_pass, session_timeout,
		update_active, boot_done, access_open, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cag_core.sv @@
// Gate state (flags, seen bits, block timer) and per-request decision logic.
// Depends on cag_pkg and command_access_gate_assert.svh.
`default_nettype none

module cag_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire cag_pkg::item_t   item,
	input  wire cag_pkg::cfg_t    cfg,
	output cag_pkg::result_t      result
);

	logic            open_q, update_q, boot_q, run_q;
	cag_pkg::seen_t  seen_q;
	cag_pkg::ticks_t left_q;

	logic            open_n, update_n, boot_n, run_n;
	cag_pkg::seen_t  seen_n;
	cag_pkg::ticks_t left_n;
	cag_pkg::seen_t  hit;
	logic            op;

	assign hit = cag_pkg::whitelist_hit(item.instr_byte);

	// Next state for the request in the input stage
	always_comb begin
		open_n   = open_q;
		update_n = update_q;
		boot_n   = boot_q;
		run_n    = run_q;
		seen_n   = seen_q;
		left_n   = left_q;
		op       = 1'b0;
		case (item.command)
			cag_pkg::CMD_CHECK: begin
				if (open_q) begin
					op = 1'b1;
				end else if (!boot_q && (hit != '0)) begin
					seen_n = seen_q | hit;
					if (seen_n == '1) begin
						boot_n = 1'b1;
					end
					op = 1'b1;
				end
				// end-of-boot instruction always passes
				if (item.instr_byte == cfg.end_boot_opcode) begin
					op     = 1'b1;
					boot_n = 1'b1;
				end
			end
			cag_pkg::CMD_STATUS: begin
				if ((item.status_byte & cag_pkg::UPDATE_MASK) == cag_pkg::UPDATE_MASK) begin
					update_n = 1'b1;
					open_n   = 1'b0;
					left_n   = cfg.block_ticks;
					run_n    = 1'b1;
				end else begin
					update_n = 1'b0;
					open_n   = 1'b1;
					left_n   = '0;
					run_n    = 1'b0;
				end
			end
			cag_pkg::CMD_TICK: begin
				if (run_q) begin
					if (left_q <= cag_pkg::ticks_t'(1)) begin
						left_n = '0;
						run_n  = 1'b0;
						open_n = 1'b1;
					end else begin
						left_n = left_q - cag_pkg::ticks_t'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields, taken from the state after this request
	always_comb begin
		result.instr_pass     = op;
		result.select_pass    = open_n || !boot_n;
		result.update_active  = update_n;
		result.boot_done      = boot_n;
		result.access_open    = open_n;
		if (update_n) begin
			result.session_timeout = boot_n ? cfg.smallest_timeout : cfg.upgrade_timeout;
		end else begin
			result.session_timeout = cfg.regular_timeout;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b1;
			update_q <= 1'b0;
			boot_q   <= 1'b0;
			run_q    <= 1'b0;
			seen_q   <= '0;
			left_q   <= '0;
		end else if (step) begin
			open_q   <= open_n;
			update_q <= update_n;
			boot_q   <= boot_n;
			run_q    <= run_n;
			seen_q   <= seen_n;
			left_q   <= left_n;
		end
	end

`include "command_access_gate_assert.svh"

	`CAG_ASSERT(a_run_closed, !(run_q && open_q), "block timer running while access open")
	`CAG_ASSERT(a_idle_timer_zero, run_q || (left_q == '0), "stopped timer holds ticks")
	`CAG_ASSERT(a_seen_ends_boot, (seen_q != '1) || boot_q, "all seen bits set in early boot")
	`CAG_ASSERT_NEXT(a_boot_sticky, boot_q, boot_q, "early boot restarted")

endmodule

`default_nettype wire

@@ hw/rtl/command_access_gate.sv @@
// Command access gate: request register, single-pass decision logic, result register.
// Requests are registered in the input stage, then their results in the result stage.
// Throughput: one request per cycle while results are taken; a waiting result holds
// the result register, and the input register takes one more request before it stalls.
// Reset (arst_n low, asynchronous): access open, early boot running, timer stopped,
// configuration zero, both stages empty. Depends on cag_pkg, cag_channels, cag_core.
`default_nettype none

module command_access_gate (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	cag_req_if.sink                      req,
	cag_rsp_if.source                    rsp,
	input  wire logic                    cfg_we,
	input  wire logic [cag_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [cag_pkg::TICKS_W-1:0] cfg_wdata
);

	cag_pkg::cfg_t    cfg_q;
	logic             v_s1, v_s2;
	cag_pkg::item_t   item_s1;
	cag_pkg::result_t res_s2;
	cag_pkg::result_t res_next;
	logic             step;
	logic             req_fire;

	// Handshake: stage 1 moves when the result register is free or drains
	assign step      = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || step;
	assign req_fire  = req.valid && req.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cag_pkg::reg_idx_t'(cfg_index))
				cag_pkg::REG_BLOCK_TICKS:  cfg_q.block_ticks      <= cfg_wdata;
				cag_pkg::REG_END_BOOT:     cfg_q.end_boot_opcode  <= cfg_wdata[cag_pkg::BYTE_W-1:0];
				cag_pkg::REG_REGULAR_TMO:  cfg_q.regular_timeout  <= cfg_wdata[cag_pkg::TMO_W-1:0];
				cag_pkg::REG_UPGRADE_TMO:  cfg_q.upgrade_timeout  <= cfg_wdata[cag_pkg::TMO_W-1:0];
				cag_pkg::REG_SMALLEST_TMO: cfg_q.smallest_timeout <= cfg_wdata[cag_pkg::TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_fire) begin
			v_s1 <= 1'b1;
		end else if (step) begin
			v_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1.command     <= req.command;
			item_s1.instr_byte  <= req.instr_byte;
			item_s1.status_byte <= req.status_byte;
		end
	end

	cag_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (step) begin
			v_s2 <= 1'b1;
		end else if (rsp.ready) begin
			v_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_next;
		end
	end

	assign rsp.valid           = v_s2;
	assign rsp.instr_pass      = res_s2.instr_pass;
	assign rsp.select_pass     = res_s2.select_pass;
	assign rsp.session_timeout = res_s2.session_timeout;
	assign rsp.update_active   = res_s2.update_active;
	assign rsp.boot_done       = res_s2.boot_done;
	assign rsp.access_open     = res_s2.access_open;

endmodule

`default_nettype wire
